// ----- hdl/uwl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whitelist table package
// Sizes, request and status codes, and the control bundle that the sequencer
// sends to the identifier store.
// ----------------------------------------------------------------------------
package uwl_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 16;
    localparam int UID_BYTES   = 4;

    // Bytes of the identifier that take part in compare and store.
    localparam int KEY_BYTES = (UID_BYTES > 4) ? 4 : ((UID_BYTES < 1) ? 1 : UID_BYTES);
    localparam logic [31:0] KEY_MASK = 32'hFFFF_FFFF >> (32 - 8 * KEY_BYTES);

    // Slot address and entry count widths.
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    // Fixed widths of the item fields.
    localparam int KIND_W   = 2;
    localparam int UID_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int ECNT_W   = 5;
    localparam int FCNT_W   = 8;

    localparam logic [FCNT_W-1:0] FCNT_MAX = {FCNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_ENTRIES);

    typedef enum logic [KIND_W-1:0] {
        KIND_CHECK  = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Requests from the sequencer to the identifier store.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [UID_W-1:0]  wr_data;
    } t_store_ctrl;

endpackage

// ----- hdl/uwl_id_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whitelist identifier store
// Single-port-write, registered-read memory of identifiers with the shared
// key comparator on its read data.
// ----------------------------------------------------------------------------
module uwl_id_store (
    input  logic                        i_clk,
    input  uwl_pkg::t_store_ctrl        i_ctrl,
    input  logic [uwl_pkg::UID_W-1:0]   i_key,
    output logic [uwl_pkg::UID_W-1:0]   o_rd_data,
    output logic                        o_match
);

    logic [uwl_pkg::UID_W-1:0] r_mem [uwl_pkg::MAX_ENTRIES];
    logic [uwl_pkg::UID_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_ctrl.wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_ctrl.rd_addr];
        end
    end

    // Shared comparator against the request key.
    assign o_match   = (r_rd_data == i_key);
    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/uid_whitelist_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card identifier whitelist table
// Check, add, delete and clear-failure requests against a packed table of
// identifiers, searched one slot per cycle through a single comparator.
// ----------------------------------------------------------------------------
// Sequence: a search reads one slot per cycle through the table; a delete
// of slot p then moves each later entry down one slot, with a read in
// S_SHIFT_RD and a write in S_SHIFT_WR, before the count drops by one.
// Clear-failures goes straight to S_OUT. A stalled output holds the result in S_OUT.
// Throughput: one item at a time; the store's single read port sets the pace.
// Reset: synchronous, active low; the table is empty and the failure count
// is zero. Stored identifiers are not cleared.
module uid_whitelist_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [uwl_pkg::KIND_W-1:0]     i_kind,
    input  logic [uwl_pkg::UID_W-1:0]      i_uid,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [uwl_pkg::STATUS_W-1:0]   o_status,
    output logic [uwl_pkg::SLOT_W-1:0]     o_slot,
    output logic [uwl_pkg::ECNT_W-1:0]     o_entry_count,
    output logic [uwl_pkg::FCNT_W-1:0]     o_failure_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } t_state;

    t_state                            r_state;
    uwl_pkg::t_kind                    r_kind;
    logic [uwl_pkg::UID_W-1:0]         r_key;
    logic [uwl_pkg::CNT_W-1:0]         r_count;
    logic [uwl_pkg::FCNT_W-1:0]        r_fail;
    logic [uwl_pkg::CNT_W-1:0]         r_idx;
    logic                              r_pend;
    logic [uwl_pkg::ADDR_W-1:0]        r_pidx;
    uwl_pkg::t_status                  r_res_status;
    logic [uwl_pkg::SLOT_W-1:0]        r_res_slot;
    logic                              r_out_valid;
    logic [uwl_pkg::STATUS_W-1:0]      r_status;
    logic [uwl_pkg::SLOT_W-1:0]        r_slot;
    logic [uwl_pkg::ECNT_W-1:0]        r_ecnt;
    logic [uwl_pkg::FCNT_W-1:0]        r_fcnt;

    uwl_pkg::t_store_ctrl              w_ctrl;
    logic [uwl_pkg::UID_W-1:0]         w_rd_data;
    logic                              w_match;
    logic                              w_hit;
    logic                              w_miss;
    logic                              w_in_take;
    logic                              w_out_free;

    uwl_id_store u_store (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_key     (r_key),
        .o_rd_data (w_rd_data),
        .o_match   (w_match)
    );

    // Search outcome: a hit on the slot read last cycle, or all slots done.
    assign w_hit  = r_pend && w_match;
    assign w_miss = !w_hit && (r_idx == r_count);

    assign w_in_take  = (r_state == S_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Store requests for the current step.
    always_comb begin
        w_ctrl         = '0;
        w_ctrl.rd_addr = r_idx[uwl_pkg::ADDR_W-1:0];
        case (r_state)
            S_SEARCH: begin
                w_ctrl.rd_en   = (r_idx != r_count);
                w_ctrl.wr_en   = w_miss && (r_kind == uwl_pkg::KIND_ADD)
                                 && (r_count != uwl_pkg::CNT_FULL);
                w_ctrl.wr_addr = r_count[uwl_pkg::ADDR_W-1:0];
                w_ctrl.wr_data = r_key;
            end
            S_SHIFT_RD: begin
                w_ctrl.rd_en = (r_idx < r_count);
            end
            S_SHIFT_WR: begin
                w_ctrl.wr_en   = 1'b1;
                w_ctrl.wr_addr = uwl_pkg::ADDR_W'(r_idx - uwl_pkg::CNT_W'(1));
                w_ctrl.wr_data = w_rd_data;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, table state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fail      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register empties when its item is taken and no new
            // result is loaded in the same cycle.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_kind       <= uwl_pkg::t_kind'(i_kind);
                        r_key        <= i_uid & uwl_pkg::KEY_MASK;
                        r_idx        <= '0;
                        r_pend       <= 1'b0;
                        r_res_status <= uwl_pkg::ST_OK;
                        r_res_slot   <= '0;
                        if (uwl_pkg::t_kind'(i_kind) == uwl_pkg::KIND_CLEAR) begin
                            r_fail  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end

                S_SEARCH: begin
                    if (w_hit) begin
                        r_res_slot <= uwl_pkg::SLOT_W'(r_pidx);
                        case (r_kind)
                            uwl_pkg::KIND_CHECK: begin
                                r_fail  <= '0;
                                r_state <= S_OUT;
                            end
                            uwl_pkg::KIND_ADD: begin
                                r_res_status <= uwl_pkg::ST_DUPLICATE;
                                r_state      <= S_OUT;
                            end
                            default: begin
                                // Delete: move every later entry down one slot.
                                r_idx   <= uwl_pkg::CNT_W'(r_pidx) + uwl_pkg::CNT_W'(1);
                                r_state <= S_SHIFT_RD;
                            end
                        endcase
                    end else if (w_miss) begin
                        r_state <= S_OUT;
                        case (r_kind)
                            uwl_pkg::KIND_ADD: begin
                                if (r_count == uwl_pkg::CNT_FULL) begin
                                    r_res_status <= uwl_pkg::ST_FULL;
                                end else begin
                                    r_res_slot <= uwl_pkg::SLOT_W'(r_count);
                                    r_count    <= r_count + uwl_pkg::CNT_W'(1);
                                end
                            end
                            uwl_pkg::KIND_CHECK: begin
                                r_res_status <= uwl_pkg::ST_NOT_FOUND;
                                if (r_fail != uwl_pkg::FCNT_MAX) begin
                                    r_fail <= r_fail + uwl_pkg::FCNT_W'(1);
                                end
                            end
                            default: begin
                                r_res_status <= uwl_pkg::ST_NOT_FOUND;
                            end
                        endcase
                    end else begin
                        // Issue the next slot read; compare it next cycle.
                        r_pend <= 1'b1;
                        r_pidx <= r_idx[uwl_pkg::ADDR_W-1:0];
                        r_idx  <= r_idx + uwl_pkg::CNT_W'(1);
                    end
                end

                S_SHIFT_RD: begin
                    if (r_idx < r_count) begin
                        r_state <= S_SHIFT_WR;
                    end else begin
                        r_count <= r_count - uwl_pkg::CNT_W'(1);
                        r_state <= S_OUT;
                    end
                end

                S_SHIFT_WR: begin
                    r_idx   <= r_idx + uwl_pkg::CNT_W'(1);
                    r_state <= S_SHIFT_RD;
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_res_status;
                        r_slot      <= r_res_slot;
                        r_ecnt      <= uwl_pkg::ECNT_W'(r_count);
                        r_fcnt      <= r_fail;
                        r_state     <= S_IDLE;
                    end else begin
                        r_out_valid <= r_out_valid;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_entry_count   = r_ecnt;
    assign o_failure_count = r_fcnt;

endmodule
